/* src/sfp_pkg.sv */
// Package for the speed frame parser: shared types and constants.
// No dependencies; used by the interfaces, the parser core and the top level.
`timescale 1ns / 1ps

package sfp_pkg;

    typedef logic [7:0]         t_byte;
    typedef logic [63:0]        t_time;
    typedef logic [15:0]        t_header;
    typedef logic signed [31:0] t_speed;

    localparam t_header SFP_HEADER_RESET = 16'h3048;
    localparam t_byte   SFP_FRAME_LENGTH = 8'd4;

    typedef enum logic [4:0] {
        PH_SEARCH  = 5'b00001,
        PH_ID_HIGH = 5'b00010,
        PH_LEN_LOW = 5'b00100,
        PH_LEN_HI  = 5'b01000,
        PH_PAYLOAD = 5'b10000
    } t_phase;

    typedef struct packed {
        t_speed speed;
        t_time  frame_time;
    } t_frame;

endpackage

/* src/sfp_if.sv */
// Valid/ready channel interfaces for the speed frame parser.
// Depends on sfp_pkg for the payload types.
`timescale 1ns / 1ps

interface sfp_in_if;
    import sfp_pkg::*;

    logic  valid;
    logic  ready;
    t_byte rx_byte;
    t_time byte_time;

    modport source (output valid, output rx_byte, output byte_time, input ready);
    modport sink   (input valid, input rx_byte, input byte_time, output ready);
endinterface

interface sfp_out_if;
    import sfp_pkg::*;

    logic   valid;
    logic   ready;
    t_speed speed;
    t_time  frame_time;

    modport source (output valid, output speed, output frame_time, input ready);
    modport sink   (input valid, input speed, input frame_time, output ready);
endinterface

/* src/speed_frame_parser.sv */
// Top level of the speed frame parser: channels, header register and result register.
// Depends on sfp_pkg, sfp_in_if, sfp_out_if and sfp_core.
`timescale 1ns / 1ps

// The block takes one received byte and its timestamp per transaction on i_rx and
// looks for a two-byte identifier (low byte first), a length of four and four
// payload bytes. Each complete frame gives one transaction on o_tx carrying the
// signed little-endian speed and the timestamp of the first identifier byte.
// A byte is taken in every cycle while the result register is empty or being
// read, so the sustained rate is one byte per cycle. The result appears on o_tx
// in the cycle after the fourth payload byte is accepted. When the receiver stalls
// with a result waiting, i_rx.ready is low and no byte is accepted until that
// result has been taken. The identifier is written through i_cfg_we and i_cfg_wdata;
// the user must do so only while the block is idle, which the block does not enforce.
// Reset clears the parser to the header search, empties the result register,
// holds i_rx.ready low and restores the identifier to 0x3048.

module speed_frame_parser (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  sfp_pkg::t_header i_cfg_wdata,
    sfp_in_if.sink           i_rx,
    sfp_out_if.source        o_tx
);
    import sfp_pkg::*;

    t_header r_header_word;
    logic    r_out_valid;
    t_frame  r_out;
    logic    w_in_ready;
    logic    w_accept;
    logic    w_result_valid;
    t_frame  w_result;

    assign w_in_ready = i_rst_n && (!r_out_valid || o_tx.ready);
    assign w_accept   = i_rx.valid && w_in_ready;
    assign i_rx.ready = w_in_ready;

    sfp_core u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (w_accept),
        .i_rx_byte      (i_rx.rx_byte),
        .i_byte_time    (i_rx.byte_time),
        .i_header_word  (r_header_word),
        .o_result_valid (w_result_valid),
        .o_result       (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_header_word <= SFP_HEADER_RESET;
        end else if (i_cfg_we) begin
            r_header_word <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept && w_result_valid) begin
            r_out_valid <= 1'b1;
        end else if (o_tx.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && w_result_valid) begin
            r_out <= w_result;
        end
    end

    assign o_tx.valid      = r_out_valid;
    assign o_tx.speed      = r_out.speed;
    assign o_tx.frame_time = r_out.frame_time;

    a_result_registered: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_result_valid) |=> r_out_valid)
        else $error("A completed frame did not reach the result register.");

    a_result_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_result_valid) |=>
            (r_out.frame_time == $past(w_result.frame_time)
             && r_out.speed == $past(w_result.speed)))
        else $error("The result register does not hold the completed frame.");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_tx.ready) |-> !w_accept)
        else $error("A transaction was accepted while a stalled result was waiting.");

endmodule

/* src/sfp_core.sv */
// Parser core: header search, length check and payload assembly state.
// Depends on sfp_pkg; the result is combinational for the transaction in hand.
`timescale 1ns / 1ps

module sfp_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  sfp_pkg::t_byte   i_rx_byte,
    input  sfp_pkg::t_time   i_byte_time,
    input  sfp_pkg::t_header i_header_word,
    output logic             o_result_valid,
    output sfp_pkg::t_frame  o_result
);
    import sfp_pkg::*;

    t_phase      r_phase, n_phase;
    t_byte       r_length_low, n_length_low;
    logic [23:0] r_payload, n_payload;
    logic [1:0]  r_count, n_count;
    t_time       r_start_time, n_start_time;

    always_comb begin
        n_phase        = r_phase;
        n_length_low   = r_length_low;
        n_payload      = r_payload;
        n_count        = r_count;
        n_start_time   = r_start_time;
        o_result_valid = 1'b0;
        o_result.speed      = t_speed'({i_rx_byte, r_payload});
        o_result.frame_time = r_start_time;
        if (i_accept) begin
            case (r_phase)
                PH_ID_HIGH: begin
                    n_phase = (i_rx_byte == i_header_word[15:8]) ? PH_LEN_LOW : PH_SEARCH;
                end
                PH_LEN_LOW: begin
                    n_length_low = i_rx_byte;
                    n_phase      = PH_LEN_HI;
                end
                PH_LEN_HI: begin
                    if (r_length_low == SFP_FRAME_LENGTH && i_rx_byte == 8'd0) begin
                        n_phase   = PH_PAYLOAD;
                        n_count   = 2'd0;
                        n_payload = 24'd0;
                    end else begin
                        n_phase = PH_SEARCH;
                    end
                end
                PH_PAYLOAD: begin
                    if (r_count != 2'd3) begin
                        n_payload[{r_count, 3'b000} +: 8] = i_rx_byte;
                        n_count = r_count + 2'd1;
                    end else begin
                        o_result_valid = 1'b1;
                        n_count        = 2'd0;
                        n_payload      = 24'd0;
                        n_phase        = PH_SEARCH;
                    end
                end
                default: begin
                    if (i_rx_byte == i_header_word[7:0]) begin
                        n_start_time = i_byte_time;
                        n_phase      = PH_ID_HIGH;
                    end else begin
                        n_phase = PH_SEARCH;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_SEARCH;
            r_length_low <= '0;
            r_payload    <= '0;
            r_count      <= '0;
            r_start_time <= '0;
        end else begin
            r_phase      <= n_phase;
            r_length_low <= n_length_low;
            r_payload    <= n_payload;
            r_count      <= n_count;
            r_start_time <= n_start_time;
        end
    end

endmodule

/* sim/testbench.sv */
// Self-checking testbench for speed_frame_parser: streams timestamped bytes into the parser
// and checks every decoded speed transaction against a frame predictor held in a class.
// Depends on sfp_pkg, sfp_in_if, sfp_out_if and the speed_frame_parser RTL.
`timescale 1ns / 1ps

module testbench;
    import sfp_pkg::*;

    localparam int CLK_PERIOD     = 12;
    localparam int DRAIN_CYCLES   = 4;
    localparam int LONG_HOLD      = 300;
    localparam int WATCHDOG_LIMIT = 2000;

    typedef struct {
        t_byte data;
        t_time stamp;
    } t_rx_item;

    class speed_frame_checker;
        t_header     header_word;
        t_phase      phase;
        t_byte       length_low;
        logic [23:0] payload_low;
        int unsigned payload_count;
        t_time       start_time;
        t_frame      frames_due[$];
        int unsigned mismatches;

        function new();
            header_word   = SFP_HEADER_RESET;
            phase         = PH_SEARCH;
            length_low    = '0;
            payload_low   = '0;
            payload_count = 0;
            start_time    = '0;
            mismatches    = 0;
        endfunction

        function void write_header(t_header value);
            header_word = value;
        endfunction

        function int unsigned frames_waiting();
            return frames_due.size();
        endfunction

        function void note_byte(t_byte b, t_time stamp);
            t_frame frame;
            case (phase)
                PH_ID_HIGH: begin
                    if (b == header_word[15:8]) phase = PH_LEN_LOW;
                    else phase = PH_SEARCH;
                end
                PH_LEN_LOW: begin
                    length_low = b;
                    phase = PH_LEN_HI;
                end
                PH_LEN_HI: begin
                    if (length_low == SFP_FRAME_LENGTH && b == 8'd0) begin
                        phase = PH_PAYLOAD;
                        payload_count = 0;
                        payload_low = '0;
                    end else begin
                        phase = PH_SEARCH;
                    end
                end
                PH_PAYLOAD: begin
                    if (payload_count < 3) begin
                        payload_low[8*payload_count +: 8] = b;
                        payload_count++;
                    end else begin
                        frame.speed = t_speed'({b, payload_low});
                        frame.frame_time = start_time;
                        frames_due.push_back(frame);
                        payload_count = 0;
                        payload_low = '0;
                        phase = PH_SEARCH;
                    end
                end
                default: begin
                    if (b == header_word[7:0]) begin
                        start_time = stamp;
                        phase = PH_ID_HIGH;
                    end else begin
                        phase = PH_SEARCH;
                    end
                end
            endcase
        endfunction

        function void check_frame(t_speed speed, t_time frame_time);
            t_frame want;
            if (frames_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected frame: speed %0d time %h", speed, frame_time);
            end else begin
                want = frames_due.pop_front();
                if (speed !== want.speed || frame_time !== want.frame_time) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Frame mismatch: expected speed %0d time %h, got speed %0d time %h",
                                 want.speed, want.frame_time, speed, frame_time);
                end
            end
        endfunction

        function void report_leftover();
            if (frames_due.size() != 0) begin
                mismatches += frames_due.size();
                $display("%0d expected frame(s) never arrived", frames_due.size());
            end
        endfunction
    endclass

    logic    i_clk;
    logic    i_rst_n;
    logic    i_cfg_we;
    t_header i_cfg_wdata;
    bit      hold_request;
    int      idle_cycles;

    sfp_in_if  rx ();
    sfp_out_if tx ();

    speed_frame_checker board = new();

    speed_frame_parser DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_rx        (rx),
        .o_tx        (tx)
    );

    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (rx.valid && rx.ready) board.note_byte(rx.rx_byte, rx.byte_time);
            if (tx.valid && tx.ready) board.check_frame(tx.speed, tx.frame_time);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (rx.valid && rx.ready) || (tx.valid && tx.ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("[speed_frame_parser] ERROR");
            $finish;
        end
    end

    initial begin : receiver
        int unsigned run_length;
        int unsigned mode;
        tx.ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            if (hold_request) begin
                hold_request = 1'b0;
                tx.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
            end else begin
                mode = $urandom_range(0, 2);
                run_length = $urandom_range(1, 40);
                repeat (run_length) begin
                    case (mode)
                        0: tx.ready <= 1'b1;
                        1: tx.ready <= 1'($urandom_range(0, 1));
                        default: tx.ready <= ($urandom_range(0, 4) == 0);
                    endcase
                    @(posedge i_clk);
                end
            end
        end
    end

    function automatic t_time random_time();
        return {$urandom, $urandom};
    endfunction

    function automatic void push_byte(ref t_rx_item q[$], input t_byte b, input t_time stamp);
        t_rx_item item;
        item.data = b;
        item.stamp = stamp;
        q.push_back(item);
    endfunction

    function automatic void push_frame(ref t_rx_item q[$], input t_header hdr,
                                       input t_speed speed, input t_time first_time);
        push_byte(q, hdr[7:0], first_time);
        push_byte(q, hdr[15:8], random_time());
        push_byte(q, SFP_FRAME_LENGTH, random_time());
        push_byte(q, 8'd0, random_time());
        for (int k = 0; k < 4; k++) push_byte(q, speed[8*k +: 8], random_time());
    endfunction

    function automatic void build_random(ref t_rx_item q[$], input t_header hdr,
                                         input int unsigned count);
        int unsigned kind;
        t_byte       b;
        while (q.size() < count) begin
            kind = $urandom_range(0, 9);
            if (kind <= 5) begin
                push_frame(q, hdr, t_speed'($urandom), random_time());
            end else if (kind == 6) begin
                repeat ($urandom_range(1, 4)) push_byte(q, t_byte'($urandom), random_time());
            end else if (kind == 7) begin
                push_byte(q, hdr[7:0], random_time());
                b = hdr[15:8] ^ t_byte'($urandom_range(1, 255));
                if (hdr[7:0] != hdr[15:8] && $urandom_range(0, 2) == 0) b = hdr[7:0];
                push_byte(q, b, random_time());
            end else begin
                push_byte(q, hdr[7:0], random_time());
                push_byte(q, hdr[15:8], random_time());
                if (kind == 8) begin
                    push_byte(q, SFP_FRAME_LENGTH ^ t_byte'($urandom_range(1, 255)), random_time());
                    push_byte(q, 8'd0, random_time());
                end else begin
                    push_byte(q, SFP_FRAME_LENGTH, random_time());
                    push_byte(q, t_byte'($urandom_range(1, 255)), random_time());
                end
                repeat ($urandom_range(0, 4)) push_byte(q, t_byte'($urandom), random_time());
            end
        end
    endfunction

    task automatic send_stream(input t_rx_item items[$]);
        int unsigned burst;
        int unsigned gap;
        burst = 0;
        foreach (items[i]) begin
            if (burst == 0) begin
                burst = $urandom_range(1, 40);
                gap = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 8) : 0;
                if (gap != 0) begin
                    rx.valid <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
            end
            rx.valid <= 1'b1;
            rx.rx_byte <= items[i].data;
            rx.byte_time <= items[i].stamp;
            do @(posedge i_clk); while (!rx.ready);
            burst--;
        end
        rx.valid <= 1'b0;
    endtask

    task automatic wait_idle();
        @(posedge i_clk);
        while (board.frames_waiting() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_header(input t_header value);
        wait_idle();
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        board.write_header(value);
    endtask

    task automatic run_phase(input t_header hdr, input int unsigned count, input bit long_hold);
        t_rx_item items[$];
        write_header(hdr);
        build_random(items, hdr, count);
        if (long_hold) hold_request = 1'b1;
        send_stream(items);
    endtask

    initial begin : stimulus
        t_rx_item items[$];
        hold_request = 1'b0;
        i_rst_n <= 1'b0;
        i_cfg_we <= 1'b0;
        i_cfg_wdata <= SFP_HEADER_RESET;
        rx.valid <= 1'b0;
        rx.rx_byte <= '0;
        rx.byte_time <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Extreme speeds and timestamps, a rejected second identifier byte that
        // would itself start a header, and a frame with the wrong length.
        push_frame(items, SFP_HEADER_RESET, 32'sh8000_0000, 64'h0);
        push_frame(items, SFP_HEADER_RESET, 32'sh7FFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
        push_byte(items, SFP_HEADER_RESET[7:0], random_time());
        push_byte(items, SFP_HEADER_RESET[7:0], random_time());
        push_byte(items, SFP_HEADER_RESET[15:8], random_time());
        push_byte(items, SFP_HEADER_RESET[7:0], random_time());
        push_byte(items, SFP_HEADER_RESET[15:8], random_time());
        push_byte(items, 8'd5, random_time());
        push_byte(items, 8'd0, random_time());
        build_random(items, SFP_HEADER_RESET, items.size() + 382);
        send_stream(items);

        run_phase(16'h0000, 250, 1'b0);
        run_phase(16'hFFFF, 250, 1'b1);
        run_phase(16'h4848, 200, 1'b0);
        run_phase(t_header'($urandom), 250, 1'b0);
        run_phase(SFP_HEADER_RESET, 250, 1'b0);

        wait_idle();
        board.report_leftover();
        if (board.mismatches == 0) begin
            $display("[speed_frame_parser] OK");
        end else begin
            $display("[speed_frame_parser] ERROR");
        end
        $finish;
    end

endmodule
